>>> sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Register indexes, the result record and a packed-byte select helper.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_end;
    } t_res;

    function automatic logic [7:0] byte_of(input logic [63:0] packed_bytes,
                                           input logic [2:0]  idx);
        return packed_bytes[{idx, 3'b000} +: 8];
    endfunction

endpackage

>>> sv/sfr_match_unit.sv
// ----------------------------------------------------------------------------
// sfr_match_unit: shared prefix comparator
// Checks whether the held candidate, taken from a start offset, is a
// prefix of the pattern; also returns the candidate byte at that offset.
// ----------------------------------------------------------------------------
module sfr_match_unit #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
    input  logic [63:0] i_pat,
    input  logic [7:0]  i_byte,
    input  logic [2:0]  i_h,
    input  logic [3:0]  i_start,
    output logic        o_match,
    output logic [7:0]  o_cand_byte
);
    import sfr_pkg::*;

    always_comb begin
        logic [4:0] pos;
        logic [7:0] cb;
        o_match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pos = {1'b0, i_start} + 5'(i);
            cb  = (pos < {2'b00, i_h}) ? byte_of(i_pat, pos[2:0]) : i_byte;
            if (pos <= {2'b00, i_h} && cb != byte_of(i_pat, 3'(i))) begin
                o_match = 1'b0;
            end
        end
    end

    assign o_cand_byte = ({1'b0, i_h} > i_start) ? byte_of(i_pat, i_start[2:0]) : i_byte;

endmodule

>>> sv/sfr_out_stage.sv
// ----------------------------------------------------------------------------
// sfr_out_stage: output register
// Holds one result transaction; takes a new one in the cycle the held one
// leaves.
// ----------------------------------------------------------------------------
module sfr_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  sfr_pkg::t_res i_push_res,
    output logic          o_valid,
    input  logic          i_ready,
    output sfr_pkg::t_res o_res
);
    import sfr_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_push_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push_valid && o_push_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_valid && o_push_ready) begin
            r_res <= i_push_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> sv/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace: streaming byte find-and-replace
// Replaces each leftmost, non-overlapping pattern occurrence in a byte
// stream with a replacement string; held bytes are always a pattern prefix.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (i_cfg_*): index 0 pattern bytes, 1 pattern length,
//   2 replacement bytes, 3 replacement length. Write only while idle; any
//   write to these indexes drops held bytes. Pattern length 0 passes bytes through.
//   Input channel: one byte per transaction, i_stream_last on the final one.
//   Output channel: one byte per transaction; o_run_last marks the last
//   result of an input, o_stream_end the end of stream. A final input with
//   nothing to emit yields a bare marker with o_has_byte low.
//   Sequence: in pass-through an input is accepted and then closed; else
//   it is accepted, the shared prefix comparator checks each candidate
//   start offset (a rejected offset emits its byte in the same cycle),
//   each replacement or flush byte is emitted and the input is closed;
//   up to 8 bytes are emitted per input. A new input is taken only once
//   the previous one is closed. The first output passes through the
//   pending byte and the output register.
//   Reset clears the configuration and control registers: pass-through, nothing held.
//   Output stalls back-pressure the sequencer; no transaction is dropped.
// ----------------------------------------------------------------------------
module stream_find_replace #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_stream_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_has_byte,
    output logic                           o_run_last,
    output logic                           o_stream_end
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REPL,
        S_FLUSH,
        S_DONE
    } t_state;

    logic [63:0] r_pat;
    logic [3:0]  r_plen;
    logic [63:0] r_rep;
    logic [3:0]  r_rlen;

    t_state      r_state, n_state;
    logic [2:0]  r_held, n_held;
    logic [2:0]  r_h, n_h;
    logic [3:0]  r_start, n_start;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        r_pend_valid, n_pend_valid;
    logic [7:0]  r_pend_byte, n_pend_byte;

    logic        cfg_fire;
    logic        cfg_hit;
    logic        in_fire;
    logic [3:0]  plen_eff;
    logic [3:0]  rlen_eff;
    logic [3:0]  h_clamp;
    logic [3:0]  len;
    logic [3:0]  rem;
    logic        match;
    logic [7:0]  cand_byte;
    logic        emit_req;
    logic [7:0]  emit_byte;
    logic        can_emit;
    logic        push_valid;
    logic        push_ready;
    t_res        push_res;
    t_res        out_res;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_fire && (i_cfg_index == REG_PATTERN_BYTES ||
                                      i_cfg_index == REG_PATTERN_LENGTH ||
                                      i_cfg_index == REG_REPLACEMENT_BYTES ||
                                      i_cfg_index == REG_REPLACEMENT_LENGTH);
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;

    assign plen_eff = (r_plen > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : r_plen;
    assign rlen_eff = (r_rlen > 4'(REPLACE_MAX)) ? 4'(REPLACE_MAX) : r_rlen;
    assign h_clamp  = ({1'b0, r_held} > plen_eff - 4'd1) ? plen_eff - 4'd1
                                                          : {1'b0, r_held};
    assign len      = {1'b0, r_h} + 4'd1;
    assign rem      = len - r_start;
    assign can_emit = !r_pend_valid || push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_PATTERN_BYTES:      r_pat  <= i_cfg_data;
                REG_PATTERN_LENGTH:     r_plen <= i_cfg_data[3:0];
                REG_REPLACEMENT_BYTES:  r_rep  <= i_cfg_data;
                REG_REPLACEMENT_LENGTH: r_rlen <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    sfr_match_unit #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .i_pat       (r_pat),
        .i_byte      (r_byte),
        .i_h         (r_h),
        .i_start     (r_start),
        .o_match     (match),
        .o_cand_byte (cand_byte)
    );

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_h          = r_h;
        n_start      = r_start;
        n_idx        = r_idx;
        n_byte       = r_byte;
        n_last       = r_last;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        emit_req     = 1'b0;
        emit_byte    = '0;
        push_valid   = 1'b0;
        push_res     = '{out_byte: r_pend_byte, has_byte: 1'b1,
                         run_last: 1'b0, stream_end: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_byte  = i_in_byte;
                    n_last  = i_stream_last;
                    n_start = '0;
                    if (plen_eff == 4'd0) begin
                        n_pend_valid = 1'b1;
                        n_pend_byte  = i_in_byte;
                        n_held       = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_h     = h_clamp[2:0];
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_start < len && !match) begin
                    emit_req  = 1'b1;
                    emit_byte = cand_byte;
                    if (can_emit) begin
                        n_start = r_start + 4'd1;
                    end
                end else if (rem == plen_eff) begin
                    n_held = '0;
                    n_idx  = '0;
                    n_state = (rlen_eff != 4'd0) ? S_REPL : S_DONE;
                end else begin
                    n_held = rem[2:0];
                    n_idx  = '0;
                    n_state = (r_last && rem != 4'd0) ? S_FLUSH : S_DONE;
                end
            end
            S_REPL: begin
                emit_req  = 1'b1;
                emit_byte = byte_of(r_rep, r_idx);
                if (can_emit) begin
                    n_idx = r_idx + 3'd1;
                    if ({1'b0, r_idx} == rlen_eff - 4'd1) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FLUSH: begin
                emit_req  = 1'b1;
                emit_byte = byte_of(r_pat, r_idx);
                if (can_emit) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == r_held - 3'd1) begin
                        n_held  = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (r_pend_valid) begin
                    push_valid = 1'b1;
                    push_res   = '{out_byte: r_pend_byte, has_byte: 1'b1,
                                   run_last: 1'b1, stream_end: r_last};
                    if (push_ready) begin
                        n_pend_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else if (r_last) begin
                    push_valid = 1'b1;
                    push_res   = '{out_byte: 8'h00, has_byte: 1'b0,
                                   run_last: 1'b1, stream_end: 1'b1};
                    if (push_ready) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // older pending byte leaves once a newer one exists
        if (emit_req && can_emit) begin
            push_valid   = r_pend_valid;
            n_pend_valid = 1'b1;
            n_pend_byte  = emit_byte;
        end

        if (cfg_hit) begin
            n_held = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held       <= '0;
            r_pend_valid <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held       <= n_held;
            r_pend_valid <= n_pend_valid;
            r_last       <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h         <= n_h;
        r_start     <= n_start;
        r_idx       <= n_idx;
        r_byte      <= n_byte;
        r_pend_byte <= n_pend_byte;
    end

    sfr_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_res   (push_res),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (out_res)
    );

    assign o_out_byte   = out_res.out_byte;
    assign o_has_byte   = out_res.has_byte;
    assign o_run_last   = out_res.run_last;
    assign o_stream_end = out_res.stream_end;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending byte left over at idle");

    a_held_below_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && plen_eff != 4'd0) |-> ({1'b0, r_held} < plen_eff))
        else $error("held count not below pattern length");

    a_scan_start_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_start <= len))
        else $error("scan offset past candidate length");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_valid && push_res.stream_end) |-> (push_res.run_last && r_last))
        else $error("stream end without run end");

endmodule
